// File: rtl/vnorm_pkg.sv
// Package for the 3D vector normalizer: widths, pipeline depths and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vnorm_pkg;
   localparam int COMP_W      = 16;             // Q8.8 component
   localparam int MAG_W       = 16;             // |component|, up to 32768
   localparam int SUM_W       = 32;             // sum of squares, Q16.16
   localparam int ROOT_W      = SUM_W / 2;      // magnitude, Q8.8
   localparam int SQRT_STAGES = ROOT_W;         // one root bit per stage
   localparam int QUOT_W      = 15;             // |unit| <= 16384
   localparam int DIV_STAGES  = QUOT_W;         // one quotient bit per stage
   localparam int UNIT_SHIFT  = 14;             // Q1.14 scale

   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [ROOT_W-1:0] root_type;

   // per-lane state travelling beside the magnitude
   typedef struct packed {
      mag_type mag;
      logic    neg;
   } lane_type;
endpackage
`default_nettype wire

// File: rtl/vnorm_if.sv
// Channel interfaces for request and response transactions of the normalizer.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface vnorm_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [vnorm_pkg::COMP_W-1:0] comp_x;
   logic signed [vnorm_pkg::COMP_W-1:0] comp_y;
   logic signed [vnorm_pkg::COMP_W-1:0] comp_z;
   modport source (output valid, comp_x, comp_y, comp_z, input ready);
   modport sink   (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

interface vnorm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [vnorm_pkg::COMP_W-1:0] unit_x;
   logic signed [vnorm_pkg::COMP_W-1:0] unit_y;
   logic signed [vnorm_pkg::COMP_W-1:0] unit_z;
   logic [vnorm_pkg::ROOT_W-1:0]        length;
   logic                                zero_error;
   modport source (output valid, unit_x, unit_y, unit_z, length, zero_error, input ready);
   modport sink   (input valid, unit_x, unit_y, unit_z, length, zero_error, output ready);
endinterface
`default_nettype wire

// File: rtl/vnorm_square_lane.sv
// One component lane: absolute value, sign and square, registered.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vnorm_square_lane (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire logic signed [vnorm_pkg::COMP_W-1:0] comp,
   output      vnorm_pkg::lane_type                 lane_ff,
   output      logic [vnorm_pkg::SUM_W-1:0]         square_ff
);
   vnorm_pkg::lane_type lane_in;

   always_comb begin
      lane_in.neg = comp[vnorm_pkg::COMP_W-1];
      // -(-32768) needs the 17th bit, so negate in MAG_W+1 and keep MAG_W
      lane_in.mag = lane_in.neg ? vnorm_pkg::mag_type'(-{1'b1, comp})
                                : vnorm_pkg::mag_type'(comp);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff   <= lane_in;
         square_ff <= lane_in.mag * lane_in.mag;
      end
   end
endmodule
`default_nettype wire

// File: rtl/vnorm_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vnorm_sqrt (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [vnorm_pkg::SUM_W-1:0] radicand,
   output      vnorm_pkg::root_type         root
);
   localparam int REM_W = vnorm_pkg::ROOT_W + 3;

   logic [vnorm_pkg::SUM_W-1:0] n_ff [vnorm_pkg::SQRT_STAGES];
   logic [REM_W-1:0]            r_ff [vnorm_pkg::SQRT_STAGES];
   vnorm_pkg::root_type         q_ff [vnorm_pkg::SQRT_STAGES];

   for (genvar k = 0; k < vnorm_pkg::SQRT_STAGES; k++) begin : g_stage
      localparam int P = vnorm_pkg::SQRT_STAGES - 1 - k;
      logic [vnorm_pkg::SUM_W-1:0] n_src;
      logic [REM_W-1:0]            r_src, r2, t;
      vnorm_pkg::root_type         q_src;
      logic                        take;

      if (k == 0) begin : g_first
         assign n_src = radicand;
         assign r_src = '0;
         assign q_src = '0;
      end else begin : g_next
         assign n_src = n_ff[k-1];
         assign r_src = r_ff[k-1];
         assign q_src = q_ff[k-1];
      end

      // bring down the next bit pair, trial subtract 4q+1
      assign r2   = {r_src[REM_W-3:0], n_src[2*P+1 -: 2]};
      assign t    = {1'b0, q_src, 2'b01};
      assign take = (r2 >= t);

      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[k] <= n_src;
            r_ff[k] <= take ? r2 - t : r2;
            q_ff[k] <= {q_src[vnorm_pkg::ROOT_W-2:0], take};
         end
      end
   end

   assign root = q_ff[vnorm_pkg::SQRT_STAGES-1];
endmodule
`default_nettype wire

// File: rtl/vnorm_div_lane.sv
// One divider lane: (|c| << 14) / length, one quotient bit per stage, sign applied at the end.
// Depends on vnorm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vnorm_div_lane (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire vnorm_pkg::lane_type                 lane,
   input  wire vnorm_pkg::root_type                 divisor,
   output      logic signed [vnorm_pkg::COMP_W-1:0] unit
);
   localparam int REM_W = vnorm_pkg::ROOT_W + 1;

   logic [REM_W-1:0]             r_ff [vnorm_pkg::DIV_STAGES];
   logic [vnorm_pkg::QUOT_W-1:0] q_ff [vnorm_pkg::DIV_STAGES];
   vnorm_pkg::root_type          d_ff [vnorm_pkg::DIV_STAGES];
   logic                         s_ff [vnorm_pkg::DIV_STAGES];

   for (genvar k = 0; k < vnorm_pkg::DIV_STAGES; k++) begin : g_stage
      logic [REM_W-1:0]             r_src;
      logic [REM_W:0]               r2;
      logic [vnorm_pkg::QUOT_W-1:0] q_src;
      vnorm_pkg::root_type          d_src;
      logic                         s_src, nbit, take;

      if (k == 0) begin : g_first
         // numerator is mag << 14; for a non-zero vector the top part mag >> 1 is already below the divisor
         assign r_src = REM_W'(lane.mag >> 1);
         assign nbit  = lane.mag[0];
         assign q_src = '0;
         assign d_src = divisor;
         assign s_src = lane.neg;
      end else begin : g_next
         assign r_src = r_ff[k-1];
         assign nbit  = 1'b0;
         assign q_src = q_ff[k-1];
         assign d_src = d_ff[k-1];
         assign s_src = s_ff[k-1];
      end

      assign r2   = {r_src, nbit};
      assign take = (r2 >= (REM_W+1)'(d_src));

      always_ff @(posedge clock) begin
         if (enable) begin
            r_ff[k] <= REM_W'(take ? r2 - (REM_W+1)'(d_src) : r2);
            q_ff[k] <= {q_src[vnorm_pkg::QUOT_W-2:0], take};
            d_ff[k] <= d_src;
            s_ff[k] <= s_src;
         end
      end
   end

   logic [vnorm_pkg::COMP_W-1:0] q_ext;
   assign q_ext = vnorm_pkg::COMP_W'(q_ff[vnorm_pkg::DIV_STAGES-1]);
   assign unit  = s_ff[vnorm_pkg::DIV_STAGES-1] ? -q_ext : q_ext;
endmodule
`default_nettype wire

// File: rtl/vec3_normalize_top.sv
// Top level of the 3D vector normalizer: square lanes, sum, square root, divider lanes.
// Depends on vnorm_pkg, vnorm_if, vnorm_square_lane, vnorm_sqrt, vnorm_div_lane.
`timescale 1ns / 1ps
`default_nettype none
// Takes one Q8.8 vector per cycle when not stalled and returns its Q1.14 unit vector and
// Q8.8 magnitude through the square lanes, sum register, 16-stage square root, 15-stage
// dividers (one result bit per stage) and response register, one response per cycle when
// not stalled; three lanes square and divide the components side by side. A zero vector
// returns zeros with zero_error set. The whole pipeline stalls while a response waits unaccepted.
module vec3_normalize_top (
   input wire logic clock,
   input wire logic reset,
   vnorm_req_if.sink   req_ch,
   vnorm_rsp_if.source rsp_ch
);
   localparam int LANES   = 3;
   localparam int MAG_DLY = 1 + vnorm_pkg::SQRT_STAGES;
   localparam int LEN_DLY = vnorm_pkg::DIV_STAGES;
   localparam int ZER_DLY = 1 + vnorm_pkg::SQRT_STAGES + vnorm_pkg::DIV_STAGES;
   localparam int PIPE    = 2 + vnorm_pkg::SQRT_STAGES + vnorm_pkg::DIV_STAGES;

   logic advance;
   logic rsp_valid_ff;
   logic [PIPE-1:0] vld_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign rsp_ch.valid = rsp_valid_ff;

   logic signed [vnorm_pkg::COMP_W-1:0] comp [LANES];
   assign comp[0] = req_ch.comp_x;
   assign comp[1] = req_ch.comp_y;
   assign comp[2] = req_ch.comp_z;

   vnorm_pkg::lane_type         lane_ff [LANES];
   logic [vnorm_pkg::SUM_W-1:0] square_ff [LANES];
   vnorm_pkg::lane_type         lane_dly_ff [LANES][MAG_DLY];
   logic signed [vnorm_pkg::COMP_W-1:0] unit [LANES];

   logic [vnorm_pkg::SUM_W-1:0] sum_ff;
   logic                        zero_ff [ZER_DLY];
   vnorm_pkg::root_type         root;
   vnorm_pkg::root_type         len_ff [LEN_DLY];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      vnorm_square_lane u_sq (
         .clock     (clock),
         .enable    (advance),
         .comp      (comp[l]),
         .lane_ff   (lane_ff[l]),
         .square_ff (square_ff[l])
      );

      vnorm_div_lane u_div (
         .clock   (clock),
         .enable  (advance),
         .lane    (lane_dly_ff[l][MAG_DLY-1]),
         .divisor (root),
         .unit    (unit[l])
      );
   end

   vnorm_sqrt u_sqrt (
      .clock    (clock),
      .enable   (advance),
      .radicand (sum_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff     <= square_ff[0] + square_ff[1] + square_ff[2];
         zero_ff[0] <= (square_ff[0] | square_ff[1] | square_ff[2]) == '0;
         for (int i = 1; i < ZER_DLY; i++) zero_ff[i] <= zero_ff[i-1];
         len_ff[0] <= root;
         for (int i = 1; i < LEN_DLY; i++) len_ff[i] <= len_ff[i-1];
         for (int l = 0; l < LANES; l++) begin
            lane_dly_ff[l][0] <= lane_ff[l];
            for (int i = 1; i < MAG_DLY; i++) lane_dly_ff[l][i] <= lane_dly_ff[l][i-1];
         end
      end
   end

   // merge the lanes into the response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ch.zero_error <= zero_ff[ZER_DLY-1];
         rsp_ch.length     <= len_ff[LEN_DLY-1];
         rsp_ch.unit_x     <= zero_ff[ZER_DLY-1] ? '0 : unit[0];
         rsp_ch.unit_y     <= zero_ff[ZER_DLY-1] ? '0 : unit[1];
         rsp_ch.unit_z     <= zero_ff[ZER_DLY-1] ? '0 : unit[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[PIPE-2:0], req_ch.valid};
         rsp_valid_ff <= vld_ff[PIPE-1];
      end
   end
endmodule
`default_nettype wire
